@@ src/bcomp_pkg.sv @@
// Shared constants for the barometer compensation block.
// Holds the configuration register indexes, fixed widths, the pressure bias and pipeline depth; depends on nothing.
package bcomp_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEMP_CALIB  = 2'd0;
    localparam logic [1:0] CFG_PRESS_LOW   = 2'd1;
    localparam logic [1:0] CFG_PRESS_MID   = 2'd2;
    localparam logic [1:0] CFG_PRESS_HIGH  = 2'd3;

    // Field and register widths.
    localparam int RAW_W      = 24;
    localparam int TEMP_OUT_W = 16;
    localparam int PRESS_W    = 24;
    localparam int CFG_W      = 48;

    // Offset removed from the two linear pressure coefficients.
    localparam logic signed [16:0] PRESS_BIAS = 17'sd16384;

    // Pipeline depth from accepted start to the done strobe.
    localparam int LATENCY = 9;

endpackage

@@ src/barometer_compensation.sv @@
// Top level of the barometer compensation block: calibration registers and
// a nine-stage fixed-point datapath. Depends on bcomp_pkg.
//
// Channel      | Handshake         | Payload
// -------------+-------------------+-----------------------------------
// command      | start, busy       | raw_pressure, raw_temperature
// result       | done (one cycle)  | temperature_out, pressure_out
// config write | cfg_we            | cfg_index, cfg_data
//
// One sample pair enters each cycle; busy stays low since the pipeline never
// blocks. done is the last bit of the valid chain that runs beside the
// nine register stages of the multiply chain (temperature, its square and
// cube, then the wide partial products). rst_n clears the calibration
// registers and every stage valid bit at once. The receiver cannot stall.
module barometer_compensation
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [bcomp_pkg::RAW_W-1:0]            raw_pressure,
    input  logic [bcomp_pkg::RAW_W-1:0]            raw_temperature,
    output logic                                   done,
    output logic signed [bcomp_pkg::TEMP_OUT_W-1:0] temperature_out,
    output logic [bcomp_pkg::PRESS_W-1:0]          pressure_out,
    input  logic                                   cfg_we,
    input  logic [1:0]                             cfg_index,
    input  logic [bcomp_pkg::CFG_W-1:0]            cfg_data
);

    // Calibration registers.
    logic [39:0] temp_calib_reg;
    logic [47:0] press_low_reg;
    logic [47:0] press_mid_reg;
    logic [31:0] press_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg <= '0;
            press_low_reg  <= '0;
            press_mid_reg  <= '0;
            press_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bcomp_pkg::CFG_TEMP_CALIB: temp_calib_reg <= cfg_data[39:0];
                bcomp_pkg::CFG_PRESS_LOW:  press_low_reg  <= cfg_data[47:0];
                bcomp_pkg::CFG_PRESS_MID:  press_mid_reg  <= cfg_data[47:0];
                bcomp_pkg::CFG_PRESS_HIGH: press_high_reg <= cfg_data[31:0];
                default:                   temp_calib_reg <= temp_calib_reg;
            endcase
        end
    end

    // Coefficient fields.
    logic        [15:0] t1;
    logic signed [16:0] t2;
    logic signed [7:0]  t3;
    logic signed [16:0] p1m;
    logic signed [16:0] p2m;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic        [15:0] p5;
    logic signed [16:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;

    assign t1  = temp_calib_reg[15:0];
    assign t2  = $signed({1'b0, temp_calib_reg[31:16]});
    assign t3  = $signed(temp_calib_reg[39:32]);
    assign p1m = $signed({press_low_reg[15], press_low_reg[15:0]}) - bcomp_pkg::PRESS_BIAS;
    assign p2m = $signed({press_low_reg[31], press_low_reg[31:16]}) - bcomp_pkg::PRESS_BIAS;
    assign p3  = $signed(press_low_reg[39:32]);
    assign p4  = $signed(press_low_reg[47:40]);
    assign p5  = press_mid_reg[15:0];
    assign p6  = $signed({1'b0, press_mid_reg[31:16]});
    assign p7  = $signed(press_mid_reg[39:32]);
    assign p8  = $signed(press_mid_reg[47:40]);
    assign p9  = $signed(press_high_reg[15:0]);
    assign p10 = $signed(press_high_reg[23:16]);
    assign p11 = $signed(press_high_reg[31:24]);

    // The pipeline never blocks a transaction.
    assign busy = 1'b0;

    logic [bcomp_pkg::LATENCY-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[bcomp_pkg::LATENCY-2:0], start & ~busy};
        end
    end

    assign done = valid_reg[bcomp_pkg::LATENCY-1];

    // Stage registers.
    logic        [23:0] s1_up_reg;
    logic signed [24:0] s1_d_reg;

    logic signed [24:0] s2_ups_reg;
    logic signed [41:0] s2_dt2_reg;
    logic signed [49:0] s2_dsq_reg;
    logic        [47:0] s2_upsq_reg;
    logic signed [41:0] s2_pa_reg;
    logic signed [41:0] s2_pb_reg;
    logic signed [32:0] s2_pc3_reg;
    logic signed [32:0] s2_pc4_reg;

    logic signed [24:0] s3_ups_reg;
    logic signed [59:0] s3_tx_reg;
    logic signed [41:0] s3_pa_reg;
    logic signed [32:0] s3_pc3_reg;
    logic signed [32:0] s3_pc4_reg;
    logic signed [56:0] s3_q10_reg;
    logic signed [56:0] s3_q11_reg;
    logic signed [48:0] s3_t9_reg;
    logic signed [63:0] s3_base_reg;

    logic signed [15:0] s4_tout_reg;
    logic signed [27:0] s4_tq_reg;
    logic signed [55:0] s4_tqq_reg;
    logic signed [56:0] s4_pal_reg;
    logic signed [41:0] s4_pah_reg;
    logic signed [56:0] s4_q10l_reg;
    logic signed [56:0] s4_q10h_reg;
    logic signed [53:0] s4_q11l_reg;
    logic signed [53:0] s4_q11h_reg;
    logic signed [32:0] s4_pc3_reg;
    logic signed [32:0] s4_pc4_reg;
    logic signed [63:0] s4_base_reg;

    logic signed [15:0] s5_tout_reg;
    logic signed [63:0] s5_acc_reg;
    logic signed [56:0] s5_cul_reg;
    logic signed [39:0] s5_cuh_reg;
    logic signed [61:0] s5_c3l_reg;
    logic signed [44:0] s5_c3h_reg;
    logic signed [47:0] s5_t7_reg;
    logic signed [32:0] s5_pc4_reg;

    logic signed [15:0] s6_tout_reg;
    logic signed [63:0] s6_acc_reg;
    logic signed [50:0] s6_tcu_reg;
    logic signed [32:0] s6_pc4_reg;

    logic signed [15:0] s7_tout_reg;
    logic signed [63:0] s7_acc_reg;
    logic signed [61:0] s7_c4l_reg;
    logic signed [55:0] s7_c4h_reg;
    logic signed [58:0] s7_t8_reg;

    logic signed [15:0] s8_tout_reg;
    logic signed [63:0] s8_acc_reg;

    logic signed [15:0] tout_reg;
    logic        [23:0] pout_reg;

    // Stage 3 combinational terms.
    logic signed [48:0] ups_sq;
    logic signed [64:0] q9_w;
    assign ups_sq = $signed({1'b0, s2_upsq_reg});
    assign q9_w   = ups_sq * p9;

    // Stage 4: temperature in 2^-16 units and its saturated output.
    logic signed [27:0] tq;
    logic signed [19:0] t_floor;
    logic signed [15:0] tout_next;
    logic signed [28:0] pa_lo;
    logic signed [13:0] pa_hi;
    logic signed [28:0] q10_lo;
    logic signed [28:0] q10_hi;
    logic signed [28:0] q11_lo;
    logic signed [28:0] q11_hi;
    logic signed [44:0] p6_t;

    assign tq      = s3_tx_reg[59:32];
    assign t_floor = s3_tx_reg[59:40];
    assign pa_lo   = $signed({1'b0, s3_pa_reg[27:0]});
    assign pa_hi   = s3_pa_reg[41:28];
    assign q10_lo  = $signed({1'b0, s3_q10_reg[27:0]});
    assign q10_hi  = s3_q10_reg[56:28];
    assign q11_lo  = $signed({1'b0, s3_q11_reg[27:0]});
    assign q11_hi  = s3_q11_reg[56:28];
    assign p6_t    = p6 * tq;

    always_comb
    begin
        priority if (t_floor > 20'sd32767)
        begin
            tout_next = 16'sh7FFF;
        end
        else if (t_floor < -20'sd32768)
        begin
            tout_next = 16'sh8000;
        end
        else
        begin
            tout_next = t_floor[15:0];
        end
    end

    // Stage 5: reassemble the tq products and split the squared temperature.
    logic signed [87:0] a_w;
    logic signed [87:0] q10_w;
    logic signed [87:0] q11_w;
    logic signed [28:0] ts_lo;
    logic signed [11:0] ts_hi;
    logic signed [39:0] tsq;

    assign a_w   = (88'(s4_pah_reg) <<< 28) + 88'(s4_pal_reg);
    assign q10_w = (88'(s4_q10h_reg) <<< 28) + 88'(s4_q10l_reg);
    assign q11_w = (88'(s4_q11h_reg) <<< 28) + 88'(s4_q11l_reg);
    assign tsq   = s4_tqq_reg[55:16];
    assign ts_lo = $signed({1'b0, s4_tqq_reg[43:16]});
    assign ts_hi = s4_tqq_reg[55:44];

    // Stage 6: cube of temperature and the p3 term.
    logic signed [87:0] cu_w;
    logic signed [87:0] c3_w;
    assign cu_w = (88'(s5_cuh_reg) <<< 28) + 88'(s5_cul_reg);
    assign c3_w = (88'(s5_c3h_reg) <<< 28) + 88'(s5_c3l_reg);

    // Stage 7: split the cube for the p4 term.
    logic signed [28:0] tcu_lo;
    logic signed [22:0] tcu_hi;
    assign tcu_lo = $signed({1'b0, s6_tcu_reg[27:0]});
    assign tcu_hi = s6_tcu_reg[50:28];

    // Stage 8: the p4 term.
    logic signed [87:0] c4_w;
    assign c4_w = (88'(s7_c4h_reg) <<< 28) + 88'(s7_c4l_reg);

    // Stage 9: scale to 1/64 Pa and saturate.
    logic signed [37:0] p_floor;
    logic        [23:0] pout_next;
    assign p_floor = s8_acc_reg[63:26];

    always_comb
    begin
        priority if (p_floor < 38'sd0)
        begin
            pout_next = '0;
        end
        else if (p_floor > 38'sd16777215)
        begin
            pout_next = 24'hFFFFFF;
        end
        else
        begin
            pout_next = p_floor[23:0];
        end
    end

    // Datapath registers; the valid chain marks which stages are live.
    always_ff @(posedge clk)
    begin
        // Stage 1: offset temperature.
        s1_up_reg <= raw_pressure;
        s1_d_reg  <= $signed({1'b0, raw_temperature}) - $signed({1'b0, t1, 8'h00});

        // Stage 2: first products.
        s2_ups_reg  <= $signed({1'b0, s1_up_reg});
        s2_dt2_reg  <= s1_d_reg * t2;
        s2_dsq_reg  <= s1_d_reg * s1_d_reg;
        s2_upsq_reg <= s1_up_reg * s1_up_reg;
        s2_pa_reg   <= $signed({1'b0, s1_up_reg}) * p2m;
        s2_pb_reg   <= $signed({1'b0, s1_up_reg}) * p1m;
        s2_pc3_reg  <= $signed({1'b0, s1_up_reg}) * p3;
        s2_pc4_reg  <= $signed({1'b0, s1_up_reg}) * p4;

        // Stage 3: exact temperature and the pressure-only terms.
        s3_ups_reg  <= s2_ups_reg;
        s3_tx_reg   <= (60'(s2_dt2_reg) <<< 18) + s2_dsq_reg * t3;
        s3_pa_reg   <= s2_pa_reg;
        s3_pc3_reg  <= s2_pc3_reg;
        s3_pc4_reg  <= s2_pc4_reg;
        s3_q10_reg  <= ups_sq * p10;
        s3_q11_reg  <= ups_sq * p11;
        s3_t9_reg   <= 49'(q9_w >>> 16);
        s3_base_reg <= $signed({1'b0, 63'(p5) << 35}) + (64'(s2_pb_reg) <<< 12);

        // Stage 4: square of temperature and the tq partial products.
        s4_tout_reg <= tout_next;
        s4_tq_reg   <= tq;
        s4_tqq_reg  <= tq * tq;
        s4_pal_reg  <= pa_lo * tq;
        s4_pah_reg  <= pa_hi * tq;
        s4_q10l_reg <= q10_lo * tq;
        s4_q10h_reg <= q10_hi * tq;
        s4_q11l_reg <= q11_lo * s3_ups_reg;
        s4_q11h_reg <= q11_hi * s3_ups_reg;
        s4_pc3_reg  <= s3_pc3_reg;
        s4_pc4_reg  <= s3_pc4_reg;
        s4_base_reg <= s3_base_reg + 64'(s3_t9_reg) + (64'(p6_t) <<< 10);

        // Stage 5: fold in the tq terms, start the cube and the p3 term.
        s5_tout_reg <= s4_tout_reg;
        s5_acc_reg  <= s4_base_reg + 64'(a_w >>> 13) + 64'(q10_w >>> 32)
                       + 64'(q11_w >>> 33);
        s5_cul_reg  <= ts_lo * s4_tq_reg;
        s5_cuh_reg  <= ts_hi * s4_tq_reg;
        s5_c3l_reg  <= s4_pc3_reg * ts_lo;
        s5_c3h_reg  <= s4_pc3_reg * ts_hi;
        s5_t7_reg   <= p7 * tsq;
        s5_pc4_reg  <= s4_pc4_reg;

        // Stage 6: cube, p3 and p7 terms.
        s6_tout_reg <= s5_tout_reg;
        s6_tcu_reg  <= 51'(cu_w >>> 16);
        s6_acc_reg  <= s5_acc_reg + 64'(c3_w >>> 16) + (64'(s5_t7_reg) <<< 8);
        s6_pc4_reg  <= s5_pc4_reg;

        // Stage 7: p4 partial products and the p8 term.
        s7_tout_reg <= s6_tout_reg;
        s7_acc_reg  <= s6_acc_reg;
        s7_c4l_reg  <= s6_pc4_reg * tcu_lo;
        s7_c4h_reg  <= s6_pc4_reg * tcu_hi;
        s7_t8_reg   <= p8 * s6_tcu_reg;

        // Stage 8: final sum.
        s8_tout_reg <= s7_tout_reg;
        s8_acc_reg  <= s7_acc_reg + 64'(c4_w >>> 21) + (64'(s7_t8_reg) <<< 1);
    end

    // Stage 9: result registers, loaded only for a live transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tout_reg <= '0;
            pout_reg <= '0;
        end
        else if (valid_reg[bcomp_pkg::LATENCY-2])
        begin
            tout_reg <= s8_tout_reg;
            pout_reg <= pout_next;
        end
    end

    assign temperature_out = tout_reg;
    assign pressure_out    = pout_reg;

`ifndef ASSERT_OFF
    // Every accepted transaction yields a result after the pipeline depth.
    assert_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##9 done)
        else $error("result missing after accepted transaction");

    // A result only appears for a transaction accepted that many cycles back.
    assert_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 9))
        else $error("result without a matching transaction");

    // Result registers hold while no result is being delivered.
    assert_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!valid_reg[bcomp_pkg::LATENCY-2]) |=> $stable(pressure_out))
        else $error("pressure result changed without a transaction");
`endif

endmodule
